### rtl/aesgcm_pkg.sv
// Shared types, constants and AES helper functions of the AES-128-GCM unit.
package aesgcm_pkg;

	localparam int LENGTH_BITS = 29;
	localparam int NROUNDS = 10;
	localparam int GH_BITS_PER_CYCLE = 4;
	localparam int GH_STEPS = 128 / GH_BITS_PER_CYCLE;

	localparam logic [95:0] NONCE = 96'h5440784449675A516C5E6313;
	localparam logic [127:0] AAD_BLOCK = 128'h7175616C636F6D6D2D74657374000000;
	localparam logic [63:0] AAD_BITS = 64'd104;
	localparam logic [7:0] GF_POLY = 8'hE1;

	localparam logic [2:0] REG_KEY_HIGH = 3'd0;
	localparam logic [2:0] REG_KEY_LOW = 3'd1;
	localparam logic [2:0] REG_DECRYPT_MODE = 3'd2;
	localparam logic [2:0] REG_EXP_TAG_HIGH = 3'd3;
	localparam logic [2:0] REG_EXP_TAG_LOW = 3'd4;

	typedef enum logic [1:0] {
		KIND_DATA,
		KIND_TAG_HI,
		KIND_TAG_LO,
		KIND_AUTH
	} kind_t;

	typedef struct packed {
		logic [7:0] data_byte;
		logic       last_byte;
	} in_item_t;

	typedef struct packed {
		kind_t       kind;
		logic [7:0]  out_byte;
		logic [63:0] tag_half;
		logic        auth_ok;
		logic        end_of_run;
	} out_item_t;

	typedef enum logic [1:0] {
		AES_ZERO,
		AES_J0,
		AES_CTR
	} aes_sel_t;

	typedef enum logic [1:0] {
		GH_AAD,
		GH_CB,
		GH_LEN
	} gh_sel_t;

	typedef enum logic [4:0] {
		S_IDLE,
		S_H_GO,
		S_H_WAIT,
		S_T_GO,
		S_T_WAIT,
		S_AAD_GO,
		S_AAD_WAIT,
		S_KS_GO,
		S_KS_WAIT,
		S_BYTE,
		S_DATA,
		S_CB_GO,
		S_CB_WAIT,
		S_LEN_GO,
		S_LEN_WAIT,
		S_TAG1,
		S_TAG2,
		S_AUTH
	} state_t;

	typedef struct packed {
		logic     start_pkt;
		logic     capture;
		logic     aes_start;
		aes_sel_t aes_sel;
		logic     aes_wr_h;
		logic     aes_wr_t;
		logic     aes_wr_ks;
		logic     gh_start;
		gh_sel_t  gh_sel;
		logic     gh_wr;
		logic     cb_clear;
		logic     byte_step;
		logic     out_load;
		kind_t    out_kind;
		logic     out_eor;
	} cmd_t;

	typedef struct packed {
		logic aes_done;
		logic gh_done;
		logic out_free;
		logic last;
		logic dec;
		logic block_end;
	} sts_t;

	localparam logic [7:0] SBOX [256] = '{
		8'h63,8'h7c,8'h77,8'h7b,8'hf2,8'h6b,8'h6f,8'hc5,8'h30,8'h01,8'h67,8'h2b,8'hfe,8'hd7,8'hab,8'h76,
		8'hca,8'h82,8'hc9,8'h7d,8'hfa,8'h59,8'h47,8'hf0,8'had,8'hd4,8'ha2,8'haf,8'h9c,8'ha4,8'h72,8'hc0,
		8'hb7,8'hfd,8'h93,8'h26,8'h36,8'h3f,8'hf7,8'hcc,8'h34,8'ha5,8'he5,8'hf1,8'h71,8'hd8,8'h31,8'h15,
		8'h04,8'hc7,8'h23,8'hc3,8'h18,8'h96,8'h05,8'h9a,8'h07,8'h12,8'h80,8'he2,8'heb,8'h27,8'hb2,8'h75,
		8'h09,8'h83,8'h2c,8'h1a,8'h1b,8'h6e,8'h5a,8'ha0,8'h52,8'h3b,8'hd6,8'hb3,8'h29,8'he3,8'h2f,8'h84,
		8'h53,8'hd1,8'h00,8'hed,8'h20,8'hfc,8'hb1,8'h5b,8'h6a,8'hcb,8'hbe,8'h39,8'h4a,8'h4c,8'h58,8'hcf,
		8'hd0,8'hef,8'haa,8'hfb,8'h43,8'h4d,8'h33,8'h85,8'h45,8'hf9,8'h02,8'h7f,8'h50,8'h3c,8'h9f,8'ha8,
		8'h51,8'ha3,8'h40,8'h8f,8'h92,8'h9d,8'h38,8'hf5,8'hbc,8'hb6,8'hda,8'h21,8'h10,8'hff,8'hf3,8'hd2,
		8'hcd,8'h0c,8'h13,8'hec,8'h5f,8'h97,8'h44,8'h17,8'hc4,8'ha7,8'h7e,8'h3d,8'h64,8'h5d,8'h19,8'h73,
		8'h60,8'h81,8'h4f,8'hdc,8'h22,8'h2a,8'h90,8'h88,8'h46,8'hee,8'hb8,8'h14,8'hde,8'h5e,8'h0b,8'hdb,
		8'he0,8'h32,8'h3a,8'h0a,8'h49,8'h06,8'h24,8'h5c,8'hc2,8'hd3,8'hac,8'h62,8'h91,8'h95,8'he4,8'h79,
		8'he7,8'hc8,8'h37,8'h6d,8'h8d,8'hd5,8'h4e,8'ha9,8'h6c,8'h56,8'hf4,8'hea,8'h65,8'h7a,8'hae,8'h08,
		8'hba,8'h78,8'h25,8'h2e,8'h1c,8'ha6,8'hb4,8'hc6,8'he8,8'hdd,8'h74,8'h1f,8'h4b,8'hbd,8'h8b,8'h8a,
		8'h70,8'h3e,8'hb5,8'h66,8'h48,8'h03,8'hf6,8'h0e,8'h61,8'h35,8'h57,8'hb9,8'h86,8'hc1,8'h1d,8'h9e,
		8'he1,8'hf8,8'h98,8'h11,8'h69,8'hd9,8'h8e,8'h94,8'h9b,8'h1e,8'h87,8'he9,8'hce,8'h55,8'h28,8'hdf,
		8'h8c,8'ha1,8'h89,8'h0d,8'hbf,8'he6,8'h42,8'h68,8'h41,8'h99,8'h2d,8'h0f,8'hb0,8'h54,8'hbb,8'h16
	};

	function automatic logic [7:0] sbox(input logic [7:0] x);
		return SBOX[x];
	endfunction

	function automatic logic [7:0] xt(input logic [7:0] x);
		return {x[6:0], 1'b0} ^ (x[7] ? 8'h1b : 8'h00);
	endfunction

	// Byte 0 of a block sits in bits 127:120.
	function automatic logic [127:0] sub_shift(input logic [127:0] s);
		logic [127:0] t;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			for (int r = 0; r < 4; r++) begin
				t[127 - 8 * (4 * c + r) -: 8] = sbox(s[127 - 8 * (4 * ((c + r) % 4) + r) -: 8]);
			end
		end
		return t;
	endfunction

	function automatic logic [127:0] mix(input logic [127:0] s);
		logic [127:0] t;
		logic [7:0] a0, a1, a2, a3, x;
		t = '0;
		for (int c = 0; c < 4; c++) begin
			a0 = s[127 - 32 * c -: 8];
			a1 = s[119 - 32 * c -: 8];
			a2 = s[111 - 32 * c -: 8];
			a3 = s[103 - 32 * c -: 8];
			x = a0 ^ a1 ^ a2 ^ a3;
			t[127 - 32 * c -: 8] = a0 ^ x ^ xt(a0 ^ a1);
			t[119 - 32 * c -: 8] = a1 ^ x ^ xt(a1 ^ a2);
			t[111 - 32 * c -: 8] = a2 ^ x ^ xt(a2 ^ a3);
			t[103 - 32 * c -: 8] = a3 ^ x ^ xt(a3 ^ a0);
		end
		return t;
	endfunction

	function automatic logic [127:0] key_next(input logic [127:0] k, input logic [7:0] rc);
		logic [31:0] tw, w0, w1, w2, w3;
		tw = {sbox(k[23:16]) ^ rc, sbox(k[15:8]), sbox(k[7:0]), sbox(k[31:24])};
		w0 = k[127:96] ^ tw;
		w1 = k[95:64] ^ w0;
		w2 = k[63:32] ^ w1;
		w3 = k[31:0] ^ w2;
		return {w0, w1, w2, w3};
	endfunction

endpackage

### rtl/aes128_gcm_fixed_nonce_unit.sv
// Top level of the AES-128-GCM engine with fixed nonce and fixed AAD.
// Sequence: a byte in an open packet is captured, XORed with the keystream and output; a new
// keystream block is computed at each 16-byte boundary and each block is folded into GHASH
// after it, by the iterative AES round and the 4-bit-per-cycle GHASH multiplier. The first byte adds
// setup (hash key H, tag mask, AAD fold); the last byte adds the length block and the tag or auth result.
// Throughput: one byte at a time; the input stalls until the current byte is finished.
// Reset: asynchronous, active low; clears control, counters, accumulator and configuration.
module aes128_gcm_fixed_nonce_unit #(
	parameter int LENGTH_BITS = aesgcm_pkg::LENGTH_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_stall,
	input  aesgcm_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_stall,
	output aesgcm_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_wdata
);

	aesgcm_pkg::cmd_t cmd;
	aesgcm_pkg::sts_t sts;

	aesgcm_ctrl u_ctrl (
		.clk     (clk),
		.arst_n  (arst_n),
		.in_valid(in_valid),
		.in_stall(in_stall),
		.sts     (sts),
		.cmd     (cmd)
	);

	aesgcm_datapath #(
		.LENGTH_BITS(LENGTH_BITS)
	) u_dp (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (cmd),
		.sts      (sts),
		.in_data  (in_data),
		.cfg_we   (cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.out_valid(out_valid),
		.out_stall(out_stall),
		.out_data (out_data)
	);

endmodule

### rtl/aesgcm_aes_core.sv
// Iterative AES-128 encryption core, one round per cycle with on-the-fly key schedule.
module aesgcm_aes_core (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] blk_in,
	input  logic [127:0] key_in,
	output logic         busy,
	output logic         done,
	output logic [127:0] blk_out
);

	logic [127:0] st_q, rk_q, rk_n, ss;
	logic [7:0]   rc_q;
	logic [3:0]   rnd_q;
	logic         busy_q, done_q;

	assign rk_n = aesgcm_pkg::key_next(rk_q, rc_q);
	assign ss = aesgcm_pkg::sub_shift(st_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			rnd_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				rnd_q <= 4'd1;
			end else if (busy_q) begin
				rnd_q <= rnd_q + 4'd1;
				if (rnd_q == 4'(aesgcm_pkg::NROUNDS)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			st_q <= blk_in ^ key_in;
			rk_q <= key_in;
			rc_q <= 8'h01;
		end else if (busy_q) begin
			// The final round skips the column mix.
			st_q <= ((rnd_q == 4'(aesgcm_pkg::NROUNDS)) ? ss : aesgcm_pkg::mix(ss)) ^ rk_n;
			rk_q <= rk_n;
			rc_q <= aesgcm_pkg::xt(rc_q);
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign blk_out = st_q;

endmodule

### rtl/aesgcm_ghash.sv
// GHASH multiplier: (acc ^ x) * H in GF(2^128), a few bits per cycle.
module aesgcm_ghash (
	input  logic         clk,
	input  logic         arst_n,
	input  logic         start,
	input  logic [127:0] acc_in,
	input  logic [127:0] x_in,
	input  logic [127:0] h_in,
	output logic         busy,
	output logic         done,
	output logic [127:0] z_out
);

	localparam int CW = $clog2(aesgcm_pkg::GH_STEPS);

	logic [127:0] y_q, z_q, v_q, y_n, z_n, v_n;
	logic [CW-1:0] cnt_q;
	logic busy_q, done_q;

	always_comb begin
		y_n = y_q;
		z_n = z_q;
		v_n = v_q;
		for (int j = 0; j < aesgcm_pkg::GH_BITS_PER_CYCLE; j++) begin
			if (y_n[127]) begin
				z_n = z_n ^ v_n;
			end
			v_n = {1'b0, v_n[127:1]} ^ (v_n[0] ? {aesgcm_pkg::GF_POLY, 120'b0} : 128'b0);
			y_n = {y_n[126:0], 1'b0};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + 1'b1;
				if (cnt_q == CW'(aesgcm_pkg::GH_STEPS - 1)) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			y_q <= acc_in ^ x_in;
			z_q <= '0;
			v_q <= h_in;
		end else if (busy_q) begin
			y_q <= y_n;
			z_q <= z_n;
			v_q <= v_n;
		end
	end

	assign busy = busy_q;
	assign done = done_q;
	assign z_out = z_q;

endmodule

### rtl/aesgcm_datapath.sv
// Datapath: configuration registers, GCM state, AES and GHASH units, output register.
module aesgcm_datapath #(
	parameter int LENGTH_BITS = aesgcm_pkg::LENGTH_BITS
) (
	input  logic                  clk,
	input  logic                  arst_n,
	input  aesgcm_pkg::cmd_t      cmd,
	output aesgcm_pkg::sts_t      sts,
	input  aesgcm_pkg::in_item_t  in_data,
	input  logic                  cfg_we,
	input  logic [2:0]            cfg_index,
	input  logic [63:0]           cfg_wdata,
	output logic                  out_valid,
	input  logic                  out_stall,
	output aesgcm_pkg::out_item_t out_data
);

	logic [63:0]  key_hi_q, key_lo_q, exp_hi_q, exp_lo_q;
	logic         dec_mode_q;
	logic [127:0] key_q, h_q, tmask_q, acc_q, ks_q, cb_q;
	logic [31:0]  ctr_q, ctr_n;
	logic [3:0]   pos_q;
	logic [LENGTH_BITS-1:0] cnt_q;
	logic [7:0]   din_q, dout_q, dout_n;
	logic         last_q, dec_q;
	logic         out_valid_q;
	aesgcm_pkg::out_item_t out_q;

	logic [127:0] aes_in, aes_out, gh_x, gh_z, tag;
	logic         aes_busy, aes_done, gh_busy, gh_done;

	assign ctr_n = ctr_q + 32'd1;
	assign dout_n = din_q ^ ks_q[127 - 8 * pos_q -: 8];
	assign tag = acc_q ^ tmask_q;

	always_comb begin
		case (cmd.aes_sel)
			aesgcm_pkg::AES_J0:  aes_in = {aesgcm_pkg::NONCE, 32'd1};
			aesgcm_pkg::AES_CTR: aes_in = {aesgcm_pkg::NONCE, ctr_n};
			default:             aes_in = '0;
		endcase
	end

	always_comb begin
		case (cmd.gh_sel)
			aesgcm_pkg::GH_AAD: gh_x = aesgcm_pkg::AAD_BLOCK;
			aesgcm_pkg::GH_CB:  gh_x = cb_q;
			default: gh_x = {aesgcm_pkg::AAD_BITS, {(61 - LENGTH_BITS){1'b0}}, cnt_q, 3'b000};
		endcase
	end

	aesgcm_aes_core u_aes (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (cmd.aes_start),
		.blk_in (aes_in),
		.key_in (key_q),
		.busy   (aes_busy),
		.done   (aes_done),
		.blk_out(aes_out)
	);

	aesgcm_ghash u_ghash (
		.clk   (clk),
		.arst_n(arst_n),
		.start (cmd.gh_start),
		.acc_in(acc_q),
		.x_in  (gh_x),
		.h_in  (h_q),
		.busy  (gh_busy),
		.done  (gh_done),
		.z_out (gh_z)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			key_hi_q <= '0;
			key_lo_q <= '0;
			exp_hi_q <= '0;
			exp_lo_q <= '0;
			dec_mode_q <= 1'b0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				aesgcm_pkg::REG_KEY_HIGH:     key_hi_q <= cfg_wdata;
				aesgcm_pkg::REG_KEY_LOW:      key_lo_q <= cfg_wdata;
				aesgcm_pkg::REG_DECRYPT_MODE: dec_mode_q <= cfg_wdata[0];
				aesgcm_pkg::REG_EXP_TAG_HIGH: exp_hi_q <= cfg_wdata;
				aesgcm_pkg::REG_EXP_TAG_LOW:  exp_lo_q <= cfg_wdata;
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			acc_q <= '0;
			cb_q <= '0;
			ctr_q <= 32'd1;
			pos_q <= '0;
			cnt_q <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (cmd.start_pkt) begin
				acc_q <= '0;
				cb_q <= '0;
				ctr_q <= 32'd1;
				pos_q <= '0;
				cnt_q <= '0;
			end
			if (cmd.aes_start && cmd.aes_sel == aesgcm_pkg::AES_CTR) begin
				ctr_q <= ctr_n;
			end
			if (cmd.gh_wr) begin
				acc_q <= gh_z;
			end
			if (cmd.byte_step) begin
				cb_q[127 - 8 * pos_q -: 8] <= dec_q ? din_q : dout_n;
				pos_q <= pos_q + 4'd1;
				cnt_q <= cnt_q + 1'b1;
			end
			if (cmd.cb_clear) begin
				cb_q <= '0;
				pos_q <= '0;
			end
			if (cmd.out_load) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.start_pkt) begin
			key_q <= {key_hi_q, key_lo_q};
		end
		if (cmd.capture) begin
			din_q <= in_data.data_byte;
			last_q <= in_data.last_byte;
			dec_q <= dec_mode_q;
		end
		if (cmd.aes_wr_h) begin
			h_q <= aes_out;
		end
		if (cmd.aes_wr_t) begin
			tmask_q <= aes_out;
		end
		if (cmd.aes_wr_ks) begin
			ks_q <= aes_out;
		end
		if (cmd.byte_step) begin
			dout_q <= dout_n;
		end
		if (cmd.out_load) begin
			out_q.kind <= cmd.out_kind;
			out_q.end_of_run <= cmd.out_eor;
			out_q.out_byte <= (cmd.out_kind == aesgcm_pkg::KIND_DATA) ? dout_q : 8'h00;
			out_q.tag_half <= (cmd.out_kind == aesgcm_pkg::KIND_TAG_HI) ? tag[127:64] :
				(cmd.out_kind == aesgcm_pkg::KIND_TAG_LO) ? tag[63:0] : 64'd0;
			out_q.auth_ok <= (cmd.out_kind == aesgcm_pkg::KIND_AUTH) &&
				(tag == {exp_hi_q, exp_lo_q});
		end
	end

	assign sts.aes_done = aes_done;
	assign sts.gh_done = gh_done;
	assign sts.out_free = !out_valid_q || !out_stall;
	assign sts.last = last_q;
	assign sts.dec = dec_q;
	assign sts.block_end = (pos_q == 4'd0) || last_q;

	assign out_valid = out_valid_q;
	assign out_data = out_q;

`ifndef SYNTH
	a_out_no_overwrite: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.out_load |-> (!out_valid_q || !out_stall))
		else $error("result register overwritten while stalled");
	a_aes_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.aes_start |-> !aes_busy)
		else $error("AES started while busy");
	a_gh_idle_start: assert property (@(posedge clk) disable iff (!arst_n)
		cmd.gh_start |-> (!gh_busy && !aes_busy))
		else $error("GHASH started while a unit is busy");
`endif

endmodule

### rtl/aesgcm_ctrl.sv
// Controller state machine sequencing packet setup, keystream, GHASH and results.
module aesgcm_ctrl (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_stall,
	input  aesgcm_pkg::sts_t    sts,
	output aesgcm_pkg::cmd_t    cmd
);

	aesgcm_pkg::state_t state_q, state_n;
	logic in_packet_q;
	logic accept;

	assign accept = in_valid && (state_q == aesgcm_pkg::S_IDLE);
	assign in_stall = (state_q != aesgcm_pkg::S_IDLE);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= aesgcm_pkg::S_IDLE;
			in_packet_q <= 1'b0;
		end else begin
			state_q <= state_n;
			if (accept) begin
				in_packet_q <= 1'b1;
			end else if (state_q == aesgcm_pkg::S_LEN_WAIT && sts.gh_done) begin
				in_packet_q <= 1'b0;
			end
		end
	end

	always_comb begin
		state_n = state_q;
		unique case (state_q)
			aesgcm_pkg::S_IDLE: begin
				if (in_valid) begin
					if (!in_packet_q) begin
						state_n = aesgcm_pkg::S_H_GO;
					end else if (sts.block_end && !sts.last) begin
						// The position counter is zero here, so a new keystream block is due.
						state_n = aesgcm_pkg::S_KS_GO;
					end else begin
						state_n = aesgcm_pkg::S_BYTE;
					end
				end
			end
			aesgcm_pkg::S_H_GO:   state_n = aesgcm_pkg::S_H_WAIT;
			aesgcm_pkg::S_H_WAIT: if (sts.aes_done) state_n = aesgcm_pkg::S_T_GO;
			aesgcm_pkg::S_T_GO:   state_n = aesgcm_pkg::S_T_WAIT;
			aesgcm_pkg::S_T_WAIT: if (sts.aes_done) state_n = aesgcm_pkg::S_AAD_GO;
			aesgcm_pkg::S_AAD_GO: state_n = aesgcm_pkg::S_AAD_WAIT;
			aesgcm_pkg::S_AAD_WAIT: if (sts.gh_done) state_n = aesgcm_pkg::S_KS_GO;
			aesgcm_pkg::S_KS_GO:  state_n = aesgcm_pkg::S_KS_WAIT;
			aesgcm_pkg::S_KS_WAIT: if (sts.aes_done) state_n = aesgcm_pkg::S_BYTE;
			aesgcm_pkg::S_BYTE:   state_n = aesgcm_pkg::S_DATA;
			aesgcm_pkg::S_DATA: begin
				if (sts.out_free) begin
					state_n = sts.block_end ? aesgcm_pkg::S_CB_GO : aesgcm_pkg::S_IDLE;
				end
			end
			aesgcm_pkg::S_CB_GO: state_n = aesgcm_pkg::S_CB_WAIT;
			aesgcm_pkg::S_CB_WAIT: begin
				if (sts.gh_done) begin
					state_n = sts.last ? aesgcm_pkg::S_LEN_GO : aesgcm_pkg::S_IDLE;
				end
			end
			aesgcm_pkg::S_LEN_GO: state_n = aesgcm_pkg::S_LEN_WAIT;
			aesgcm_pkg::S_LEN_WAIT: begin
				if (sts.gh_done) begin
					state_n = sts.dec ? aesgcm_pkg::S_AUTH : aesgcm_pkg::S_TAG1;
				end
			end
			aesgcm_pkg::S_TAG1: if (sts.out_free) state_n = aesgcm_pkg::S_TAG2;
			aesgcm_pkg::S_TAG2: if (sts.out_free) state_n = aesgcm_pkg::S_IDLE;
			aesgcm_pkg::S_AUTH: if (sts.out_free) state_n = aesgcm_pkg::S_IDLE;
			default: state_n = aesgcm_pkg::S_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		cmd.aes_sel = aesgcm_pkg::AES_ZERO;
		cmd.gh_sel = aesgcm_pkg::GH_AAD;
		cmd.out_kind = aesgcm_pkg::KIND_DATA;
		unique case (state_q)
			aesgcm_pkg::S_IDLE: begin
				cmd.capture = accept;
				cmd.start_pkt = accept && !in_packet_q;
			end
			aesgcm_pkg::S_H_GO: cmd.aes_start = 1'b1;
			aesgcm_pkg::S_H_WAIT: cmd.aes_wr_h = sts.aes_done;
			aesgcm_pkg::S_T_GO: begin
				cmd.aes_start = 1'b1;
				cmd.aes_sel = aesgcm_pkg::AES_J0;
			end
			aesgcm_pkg::S_T_WAIT: cmd.aes_wr_t = sts.aes_done;
			aesgcm_pkg::S_AAD_GO: cmd.gh_start = 1'b1;
			aesgcm_pkg::S_AAD_WAIT: cmd.gh_wr = sts.gh_done;
			aesgcm_pkg::S_KS_GO: begin
				cmd.aes_start = 1'b1;
				cmd.aes_sel = aesgcm_pkg::AES_CTR;
			end
			aesgcm_pkg::S_KS_WAIT: cmd.aes_wr_ks = sts.aes_done;
			aesgcm_pkg::S_BYTE: cmd.byte_step = 1'b1;
			aesgcm_pkg::S_DATA: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = aesgcm_pkg::KIND_DATA;
				cmd.out_eor = !sts.last;
			end
			aesgcm_pkg::S_CB_GO: begin
				cmd.gh_start = 1'b1;
				cmd.gh_sel = aesgcm_pkg::GH_CB;
			end
			aesgcm_pkg::S_CB_WAIT: begin
				cmd.gh_wr = sts.gh_done;
				cmd.cb_clear = sts.gh_done;
			end
			aesgcm_pkg::S_LEN_GO: begin
				cmd.gh_start = 1'b1;
				cmd.gh_sel = aesgcm_pkg::GH_LEN;
			end
			aesgcm_pkg::S_LEN_WAIT: cmd.gh_wr = sts.gh_done;
			aesgcm_pkg::S_TAG1: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = aesgcm_pkg::KIND_TAG_HI;
			end
			aesgcm_pkg::S_TAG2: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = aesgcm_pkg::KIND_TAG_LO;
				cmd.out_eor = 1'b1;
			end
			aesgcm_pkg::S_AUTH: begin
				cmd.out_load = sts.out_free;
				cmd.out_kind = aesgcm_pkg::KIND_AUTH;
				cmd.out_eor = 1'b1;
			end
			default: ;
		endcase
	end

`ifndef SYNTH
	a_accept_only_idle: assert property (@(posedge clk) disable iff (!arst_n)
		(in_valid && !in_stall) |=> (state_q != aesgcm_pkg::S_IDLE))
		else $error("accepted item did not leave idle");
	a_setup_on_new_packet: assert property (@(posedge clk) disable iff (!arst_n)
		(accept && !in_packet_q) |=> (state_q == aesgcm_pkg::S_H_GO))
		else $error("packet setup skipped");
	a_packet_closes: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == aesgcm_pkg::S_TAG1 || state_q == aesgcm_pkg::S_AUTH) |-> !in_packet_q)
		else $error("packet still open while tag is emitted");
`endif

endmodule
